### hdl/slc_pkg.sv
// Package for the source line classifier: character codes, counter sizing,
// the parser state and counter-increment structs, and the channel word types.
// No dependencies.
`timescale 1ns / 1ps

package slc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int NUM_COUNTERS = 5;
   localparam int OUT_WIDTH = 32;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   localparam int CNT_TOTAL = 0;
   localparam int CNT_EMPTY = 1;
   localparam int CNT_SOURCE = 2;
   localparam int CNT_COMMENT = 3;
   localparam int CNT_BLOCK = 4;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      CMT_NONE = 2'd0,
      CMT_SET = 2'd1,
      CMT_BLOCKED = 2'd2
   } cmt_flag_type;

   typedef struct packed {
      logic block_open;
      logic line_source;
      cmt_flag_type line_comment;
      logic line_block;
      logic leading_done;
      logic [1:0] seg_pos;
      logic [7:0] prev_char;
      logic slash_before_prev;
      logic rest_ignored;
   } line_state_type;

   typedef struct packed {
      logic total;
      logic empty;
      logic source;
      logic comment;
      logic block;
   } bump_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic line_end;
      logic file_start;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] total_lines;
      logic [OUT_WIDTH-1:0] empty_lines;
      logic [OUT_WIDTH-1:0] source_lines;
      logic [OUT_WIDTH-1:0] comment_lines;
      logic [OUT_WIDTH-1:0] block_comment_lines;
      logic inside_block;
   } rsp_type;

   // Low output bits of a counter, zero-extended when the counter is narrower.
   function automatic logic [OUT_WIDTH-1:0] count_to_out(count_type c);
      logic [63:0] wide;
      wide = 64'(c);
      return wide[OUT_WIDTH-1:0];
   endfunction

endpackage

### hdl/slc_line_parser.sv
// Per-character line parser for the source line classifier: holds the
// comment and segment state and reports which counters a finished line bumps.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_line_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  slc_pkg::req_type  word,
   output slc_pkg::bump_type bump,
   output logic              block_open
);

   slc_pkg::line_state_type st_ff;
   slc_pkg::line_state_type st_in;

   logic [7:0] c;
   logic blk;
   logic slash_star;
   slc_pkg::cmt_flag_type cmt;

   assign c = word.char_code;
   assign block_open = st_ff.block_open;

   always_comb begin
      st_in = st_ff;
      bump = '0;
      cmt = slc_pkg::CMT_NONE;
      blk = st_ff.block_open & ~word.file_start;
      slash_star = (st_ff.prev_char == slc_pkg::CHAR_SLASH) && (c == slc_pkg::CHAR_STAR);
      st_in.block_open = blk;
      if (word.line_end) begin
         bump.total = 1'b1;
         if (!st_ff.leading_done) begin
            bump.empty = 1'b1;
         end else begin
            bump.source = st_ff.line_source
                          | (!blk && !st_ff.rest_ignored && st_ff.seg_pos == 2'd1);
            bump.comment = (st_ff.line_comment == slc_pkg::CMT_SET);
            bump.block = st_ff.line_block;
         end
         st_in = '0;
         st_in.block_open = blk;
      end else if (!st_ff.leading_done
                   && (c == slc_pkg::CHAR_SPACE || c == slc_pkg::CHAR_TAB)) begin
         st_in.block_open = blk;
      end else begin
         if (st_ff.leading_done) begin
            cmt = st_ff.line_comment;
         end else begin
            cmt = blk ? slc_pkg::CMT_BLOCKED : slc_pkg::CMT_NONE;
         end
         st_in.leading_done = 1'b1;
         st_in.line_comment = cmt;
         if (!st_ff.rest_ignored) begin
            // Default action is to shift the character into the segment; the
            // branches below override it where a delimiter is recognized.
            st_in.slash_before_prev = (st_ff.seg_pos != 2'd0)
                                      && (st_ff.prev_char == slc_pkg::CHAR_SLASH);
            st_in.prev_char = c;
            st_in.seg_pos = (st_ff.seg_pos == 2'd2) ? 2'd2 : st_ff.seg_pos + 2'd1;
            if (blk) begin
               st_in.line_block = 1'b1;
               if (st_ff.seg_pos != 2'd0 && st_ff.prev_char == slc_pkg::CHAR_STAR
                   && c == slc_pkg::CHAR_SLASH) begin
                  st_in.block_open = 1'b0;
                  st_in.seg_pos = 2'd0;
                  st_in.prev_char = 8'd0;
                  st_in.slash_before_prev = 1'b0;
               end
            end else if (st_ff.seg_pos == 2'd1) begin
               if (st_ff.prev_char == slc_pkg::CHAR_SLASH && c == slc_pkg::CHAR_SLASH) begin
                  if (cmt == slc_pkg::CMT_NONE) begin
                     st_in.line_comment = slc_pkg::CMT_SET;
                  end
                  st_in.rest_ignored = 1'b1;
                  st_in.seg_pos = st_ff.seg_pos;
                  st_in.prev_char = st_ff.prev_char;
                  st_in.slash_before_prev = st_ff.slash_before_prev;
               end else if (slash_star) begin
                  st_in.line_block = 1'b1;
                  st_in.block_open = 1'b1;
                  st_in.seg_pos = 2'd0;
                  st_in.prev_char = 8'd0;
                  st_in.slash_before_prev = 1'b0;
               end else begin
                  st_in.line_source = 1'b1;
               end
            end else if (st_ff.seg_pos == 2'd2 && slash_star) begin
               if (st_ff.slash_before_prev) begin
                  // A slash-star right after another slash is rejected.
                  st_in.rest_ignored = 1'b1;
                  st_in.seg_pos = st_ff.seg_pos;
                  st_in.prev_char = st_ff.prev_char;
                  st_in.slash_before_prev = st_ff.slash_before_prev;
               end else begin
                  st_in.line_block = 1'b1;
                  st_in.block_open = 1'b1;
                  st_in.seg_pos = 2'd0;
                  st_in.prev_char = 8'd0;
                  st_in.slash_before_prev = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (enable) begin
         st_ff <= st_in;
      end
   end

   a_rest_needs_lead: assert property (@(posedge clock) disable iff (reset)
      st_ff.rest_ignored |-> st_ff.leading_done)
      else $error("rest of line ignored before any character was seen");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      enable && word.line_end |=> !st_ff.leading_done && st_ff.seg_pos == 2'd0)
      else $error("line state not cleared at end of line");

   a_file_start_closes: assert property (@(posedge clock) disable iff (reset)
      enable && word.file_start && word.line_end |=> !st_ff.block_open)
      else $error("block comment left open across a file start");

endmodule

### hdl/slc_counters.sv
// Saturating line counter bank for the source line classifier.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_counters (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  slc_pkg::bump_type   bump,
   output slc_pkg::count_type  counts [slc_pkg::NUM_COUNTERS]
);

   slc_pkg::count_type cnt_ff [slc_pkg::NUM_COUNTERS];
   logic [slc_pkg::NUM_COUNTERS-1:0] inc;

   assign inc[slc_pkg::CNT_TOTAL] = bump.total;
   assign inc[slc_pkg::CNT_EMPTY] = bump.empty;
   assign inc[slc_pkg::CNT_SOURCE] = bump.source;
   assign inc[slc_pkg::CNT_COMMENT] = bump.comment;
   assign inc[slc_pkg::CNT_BLOCK] = bump.block;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < slc_pkg::NUM_COUNTERS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else if (enable) begin
         for (int k = 0; k < slc_pkg::NUM_COUNTERS; k++) begin
            if (inc[k] && cnt_ff[k] != '1) begin
               cnt_ff[k] <= cnt_ff[k] + slc_pkg::count_type'(1);
            end
         end
      end
   end

   assign counts = cnt_ff;

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> cnt_ff[slc_pkg::CNT_TOTAL] >= $past(cnt_ff[slc_pkg::CNT_TOTAL]))
      else $error("total line count went down");

   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[slc_pkg::CNT_TOTAL] >= cnt_ff[slc_pkg::CNT_EMPTY]
      && cnt_ff[slc_pkg::CNT_TOTAL] >= cnt_ff[slc_pkg::CNT_SOURCE]
      && cnt_ff[slc_pkg::CNT_TOTAL] >= cnt_ff[slc_pkg::CNT_COMMENT]
      && cnt_ff[slc_pkg::CNT_TOTAL] >= cnt_ff[slc_pkg::CNT_BLOCK])
      else $error("a category count exceeds the total line count");

   a_category_needs_total: assert property (@(posedge clock) disable iff (reset)
      enable && (bump.empty || bump.source || bump.comment || bump.block) |-> bump.total)
      else $error("category bumped without a line end");

endmodule

### hdl/source_line_classifier.sv
// Top level of the source line classifier: input register, line parser,
// counter bank and result handshake. Depends on slc_pkg, slc_line_parser
// and slc_counters.
`timescale 1ns / 1ps

// Takes one character word per cycle and returns one result word per input
// word: the five saturating line counts and the open-block flag as they stand
// after that word. A word with line_end set closes the line. Throughput is one
// word per clock when the result side keeps up. A word is accepted into the
// input register, and its result is written into the result register when the
// parser and counters update from it. The counters double as the result
// register, so a stalled result holds the state until it is taken while one
// more word waits in the input register.
module source_line_classifier (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slc_pkg::rsp_type rsp_data
);

   slc_pkg::req_type req_ff;
   logic req_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic step;

   slc_pkg::bump_type bump;
   logic block_open;
   slc_pkg::count_type counts [slc_pkg::NUM_COUNTERS];

   // The result stage can take a word when it is empty or being drained.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign step = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   slc_line_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .enable     (step),
      .word       (req_ff),
      .bump       (bump),
      .block_open (block_open)
   );

   slc_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .enable (step),
      .bump   (bump),
      .counts (counts)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.total_lines = slc_pkg::count_to_out(counts[slc_pkg::CNT_TOTAL]);
   assign rsp_data.empty_lines = slc_pkg::count_to_out(counts[slc_pkg::CNT_EMPTY]);
   assign rsp_data.source_lines = slc_pkg::count_to_out(counts[slc_pkg::CNT_SOURCE]);
   assign rsp_data.comment_lines = slc_pkg::count_to_out(counts[slc_pkg::CNT_COMMENT]);
   assign rsp_data.block_comment_lines =
      slc_pkg::count_to_out(counts[slc_pkg::CNT_BLOCK]);
   assign rsp_data.inside_block = block_open;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !req_valid_ff)
      else $error("pipeline not empty after reset");

   a_stalled_word_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("buffered word lost while the result side stalled");

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed word produced no result");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while waiting to be taken");

endmodule
